FILE: hdl/rvx_pkg.sv
// Shared types and encodings for the RV32IM decode/execute pipeline.
// No dependencies.
`default_nettype none
package rvx_pkg;

	localparam int XLEN       = 32;
	localparam int DIV_BITS   = 2;                  // quotient bits per divider stage
	localparam int DIV_STAGES = XLEN / DIV_BITS;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_FENCE  = 7'h0F;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MUL  = 7'h01;

	localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
	localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
	localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_ECALL   = 2'd1,
		ST_EBREAK  = 2'd2,
		ST_ILLEGAL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MK_NONE  = 2'd0,
		MK_LOADS = 2'd1,
		MK_LOADU = 2'd2,
		MK_STORE = 2'd3
	} mem_kind_t;

	typedef enum logic [2:0] {
		RES_ALU,
		RES_MUL_LO,
		RES_MUL_HI,
		RES_DIV_Q,
		RES_DIV_R
	} res_sel_t;

	typedef struct packed {
		logic [4:0]  rd_index;
		logic        rd_write;
		logic [31:0] rd_value;
		logic [31:0] next_pc;
		mem_kind_t   mem_kind;
		logic [2:0]  mem_size;
		logic [31:0] mem_addr;
		logic [31:0] mem_wdata;
		logic [11:0] csr_addr;
		logic        csr_we;
		logic [31:0] csr_wdata;
		status_t     status;
		res_sel_t    res_sel;
		logic        q_neg;
		logic        r_neg;
	} exe_t;

	typedef struct packed {
		logic [32:0] mul_a;
		logic [32:0] mul_b;
		logic [31:0] div_n;
		logic [31:0] div_d;
	} ops_t;

endpackage
`default_nettype wire

FILE: hdl/rvx_decode.sv
// Instruction decode and combinational execute: immediates, ALU, branches,
// memory request, CSR and system ops; prepares M-extension operands. Uses rvx_pkg.
`default_nettype none
module rvx_decode import rvx_pkg::*; (
	input  wire logic [31:0] instruction,
	input  wire logic [31:0] pc,
	input  wire logic [31:0] rs1_value,
	input  wire logic [31:0] rs2_value,
	input  wire logic [31:0] csr_value,
	input  wire logic [31:0] mepc_value,
	input  wire logic [31:0] mtvec_value,
	output exe_t             res,
	output ops_t             ops
);

	logic [6:0]  opcode, f7;
	logic [2:0]  f3;
	logic [4:0]  rdf, rs1f;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
	logic [31:0] a, b, pc4, src;
	logic        lt_s, lt_u, lt_si, lt_ui, take;
	logic [4:0]  shi;
	logic        a_sgn, b_sgn;
	exe_t        r;

	always_comb begin
		opcode = instruction[6:0];
		f3     = instruction[14:12];
		f7     = instruction[31:25];
		rdf    = instruction[11:7];
		rs1f   = instruction[19:15];
		a      = rs1_value;
		b      = rs2_value;
		imm_i  = {{20{instruction[31]}}, instruction[31:20]};
		imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
		imm_b  = {{19{instruction[31]}}, instruction[31], instruction[7],
			instruction[30:25], instruction[11:8], 1'b0};
		imm_u  = {instruction[31:12], 12'b0};
		imm_j  = {{11{instruction[31]}}, instruction[31], instruction[19:12],
			instruction[20], instruction[30:21], 1'b0};
		pc4    = pc + 32'd4;
		lt_s   = $signed(a) < $signed(b);
		lt_u   = a < b;
		lt_si  = $signed(a) < $signed(imm_i);
		lt_ui  = a < imm_i;
		shi    = imm_i[4:0];
		src    = f3[2] ? {27'b0, rs1f} : a;
		take   = 1'b0;

		r           = '0;
		r.rd_index  = rdf;
		r.next_pc   = pc4;
		r.mem_kind  = MK_NONE;
		r.status    = ST_NORMAL;
		r.res_sel   = RES_ALU;

		// M-extension operand prep: signed divide runs on magnitudes
		a_sgn = 1'b0;
		b_sgn = 1'b0;
		unique case (f3)
			3'd1: begin
				a_sgn = 1'b1;
				b_sgn = 1'b1;
			end
			3'd2: a_sgn = 1'b1;
			3'd4, 3'd6: begin
				a_sgn = 1'b1;
				b_sgn = 1'b1;
			end
			default: ;
		endcase
		ops.mul_a = {a_sgn & a[31], a};
		ops.mul_b = {b_sgn & b[31], b};
		ops.div_n = (a_sgn & a[31]) ? (32'd0 - a) : a;
		ops.div_d = (b_sgn & b[31]) ? (32'd0 - b) : b;

		unique case (opcode)
			OP_LUI: begin
				r.rd_write = 1'b1;
				r.rd_value = imm_u;
			end
			OP_AUIPC: begin
				r.rd_write = 1'b1;
				r.rd_value = pc + imm_u;
			end
			OP_JAL: begin
				r.rd_write = 1'b1;
				r.rd_value = pc4;
				r.next_pc  = pc + imm_j;
			end
			OP_JALR: begin
				if (f3 != 3'd0) begin
					r.status = ST_ILLEGAL;
				end else begin
					r.rd_write = 1'b1;
					r.rd_value = pc4;
					r.next_pc  = (a + imm_i) & ~32'd1;
				end
			end
			OP_BRANCH: begin
				unique case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = lt_s;
					3'd5: take = !lt_s;
					3'd6: take = lt_u;
					3'd7: take = !lt_u;
					default: r.status = ST_ILLEGAL;
				endcase
				if (take) r.next_pc = pc + imm_b;
			end
			OP_LOAD: begin
				r.mem_addr = a + imm_i;
				unique case (f3)
					3'd0: begin r.mem_kind = MK_LOADS; r.mem_size = 3'd1; end
					3'd1: begin r.mem_kind = MK_LOADS; r.mem_size = 3'd2; end
					3'd2: begin r.mem_kind = MK_LOADS; r.mem_size = 3'd4; end
					3'd4: begin r.mem_kind = MK_LOADU; r.mem_size = 3'd1; end
					3'd5: begin r.mem_kind = MK_LOADU; r.mem_size = 3'd2; end
					default: r.status = ST_ILLEGAL;
				endcase
			end
			OP_STORE: begin
				if (f3 > 3'd2) begin
					r.status = ST_ILLEGAL;
				end else begin
					r.mem_kind  = MK_STORE;
					r.mem_size  = 3'd1 << f3[1:0];
					r.mem_addr  = a + imm_s;
					r.mem_wdata = b;
				end
			end
			OP_IMM: begin
				r.rd_write = 1'b1;
				unique case (f3)
					3'd0: r.rd_value = a + imm_i;
					3'd2: r.rd_value = {31'b0, lt_si};
					3'd3: r.rd_value = {31'b0, lt_ui};
					3'd4: r.rd_value = a ^ imm_i;
					3'd6: r.rd_value = a | imm_i;
					3'd7: r.rd_value = a & imm_i;
					3'd1: begin
						if (f7 == F7_BASE) r.rd_value = a << shi;
						else r.status = ST_ILLEGAL;
					end
					default: begin
						if (f7 == F7_BASE) r.rd_value = a >> shi;
						else if (f7 == F7_ALT) r.rd_value = 32'($signed(a) >>> shi);
						else r.status = ST_ILLEGAL;
					end
				endcase
			end
			OP_REG: begin
				r.rd_write = 1'b1;
				if (f7 == F7_MUL) begin
					unique case (f3)
						3'd0: r.res_sel = RES_MUL_LO;
						3'd1, 3'd2, 3'd3: r.res_sel = RES_MUL_HI;
						3'd4, 3'd5: r.res_sel = RES_DIV_Q;
						default: r.res_sel = RES_DIV_R;
					endcase
					// zero divisor gives all-ones magnitude: keep it unsigned
					r.q_neg = a_sgn & (a[31] ^ b[31]) & (b != 32'd0);
					r.r_neg = a_sgn & a[31];
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) r.rd_value = a - b;
					else if (f3 == 3'd5) r.rd_value = 32'($signed(a) >>> b[4:0]);
					else r.status = ST_ILLEGAL;
				end else if (f7 == F7_BASE) begin
					unique case (f3)
						3'd0: r.rd_value = a + b;
						3'd1: r.rd_value = a << b[4:0];
						3'd2: r.rd_value = {31'b0, lt_s};
						3'd3: r.rd_value = {31'b0, lt_u};
						3'd4: r.rd_value = a ^ b;
						3'd5: r.rd_value = a >> b[4:0];
						3'd6: r.rd_value = a | b;
						default: r.rd_value = a & b;
					endcase
				end else begin
					r.status = ST_ILLEGAL;
				end
			end
			OP_FENCE: begin
				if (f3 > 3'd1) r.status = ST_ILLEGAL;
			end
			OP_SYSTEM: begin
				if (f3 == 3'd0) begin
					if (instruction == INSN_ECALL) begin
						r.status  = ST_ECALL;
						r.next_pc = mtvec_value;
					end else if (instruction == INSN_EBREAK) begin
						r.status = ST_EBREAK;
					end else if (instruction == INSN_MRET) begin
						r.next_pc = mepc_value;
					end else begin
						r.status = ST_ILLEGAL;
					end
				end else if (f3 == 3'd4) begin
					r.status = ST_ILLEGAL;
				end else begin
					r.csr_addr = instruction[31:20];
					r.rd_write = 1'b1;
					r.rd_value = csr_value;
					unique case (f3[1:0])
						2'd1: begin
							r.csr_we    = 1'b1;
							r.csr_wdata = src;
						end
						2'd2: begin
							if (rs1f != 5'd0) begin
								r.csr_we    = 1'b1;
								r.csr_wdata = csr_value | src;
							end
						end
						default: begin
							if (rs1f != 5'd0) begin
								r.csr_we    = 1'b1;
								r.csr_wdata = csr_value & ~src;
							end
						end
					endcase
				end
			end
			default: r.status = ST_ILLEGAL;
		endcase

		if (r.status == ST_ILLEGAL) begin
			r           = '0;
			r.rd_index  = rdf;
			r.next_pc   = pc4;
			r.mem_kind  = MK_NONE;
			r.status    = ST_ILLEGAL;
			r.res_sel   = RES_ALU;
		end
		if (rdf == 5'd0) r.rd_write = 1'b0;
		if (!r.rd_write) begin
			r.rd_value = '0;
			r.res_sel  = RES_ALU;
		end
		res = r;
	end

endmodule
`default_nettype wire

FILE: hdl/rvx_mul.sv
// Registered 33x33 signed multiplier, returns high or low product word.
// Uses rvx_pkg.
`default_nettype none
module rvx_mul import rvx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [32:0] a,
	input  wire logic [32:0] b,
	input  wire logic        hi,
	output logic [31:0]      prod_s2
);

	logic [65:0] full;

	assign full = 66'($signed(a) * $signed(b));

	always_ff @(posedge clk) begin
		if (en) prod_s2 <= hi ? full[63:32] : full[31:0];
	end

endmodule
`default_nettype wire

FILE: hdl/rvx_div.sv
// Pipelined unsigned restoring divider, DIV_BITS quotient bits per stage,
// DIV_STAGES register stages. Uses rvx_pkg.
`default_nettype none
module rvx_div import rvx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic [31:0]      quotient,
	output logic [31:0]      remainder
);

	// n holds remaining dividend bits on top, quotient bits shift in at the bottom
	logic [31:0] rem_s [1:DIV_STAGES];
	logic [31:0] num_s [1:DIV_STAGES];
	logic [31:0] den_s [1:DIV_STAGES-1];
	logic [31:0] rem_in [DIV_STAGES];
	logic [31:0] num_in [DIV_STAGES];
	logic [31:0] den_in [DIV_STAGES];
	logic [31:0] rem_nx [DIV_STAGES];
	logic [31:0] num_nx [DIV_STAGES];

	function automatic logic [63:0] div_step(input logic [31:0] r, input logic [31:0] n,
			input logic [31:0] d);
		logic [32:0] t;
		logic [32:0] diff;
		t    = {r, n[31]};
		diff = t - {1'b0, d};
		if (!diff[32]) return {diff[31:0], n[30:0], 1'b1};
		else return {t[31:0], n[30:0], 1'b0};
	endfunction

	always_comb begin
		logic [63:0] acc;
		rem_in[0] = '0;
		num_in[0] = dividend;
		den_in[0] = divisor;
		for (int k = 1; k < DIV_STAGES; k++) begin
			rem_in[k] = rem_s[k];
			num_in[k] = num_s[k];
			den_in[k] = den_s[k];
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			acc = {rem_in[k], num_in[k]};
			for (int j = 0; j < DIV_BITS; j++) begin
				acc = div_step(acc[63:32], acc[31:0], den_in[k]);
			end
			rem_nx[k] = acc[63:32];
			num_nx[k] = acc[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k+1] <= rem_nx[k];
				num_s[k+1] <= num_nx[k];
				if (k + 1 < DIV_STAGES) den_s[k+1] <= den_in[k];
			end
		end
	end

	assign quotient  = num_s[DIV_STAGES];
	assign remainder = rem_s[DIV_STAGES];

endmodule
`default_nettype wire

FILE: hdl/rv32im_decode_execute.sv
// Top level of the RV32IM decode/execute pipeline: decode stage, multiplier,
// pipelined divider and the payload line. Uses rvx_pkg, rvx_decode, rvx_mul, rvx_div.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | instruction, pc, rs1..mtvec values
//  out     | out_valid / out_ready  | rd_*, next_pc, mem_*, csr_*, status
//
// One beat enters per cycle while in_ready is high.
// The divider sets the depth: DIV_BITS quotient bits per stage.
// The whole pipe advances together; it holds when the output beat waits.
// in_ready is high whenever the output register is empty or being taken.
// Reset clears only the valid bits.
`default_nettype none
module rv32im_decode_execute import rvx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] instruction,
	input  wire logic [31:0] pc,
	input  wire logic [31:0] rs1_value,
	input  wire logic [31:0] rs2_value,
	input  wire logic [31:0] csr_value,
	input  wire logic [31:0] mepc_value,
	input  wire logic [31:0] mtvec_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       rd_index,
	output logic             rd_write,
	output logic [31:0]      rd_value,
	output logic [31:0]      next_pc,
	output logic [1:0]       mem_kind,
	output logic [2:0]       mem_size,
	output logic [31:0]      mem_addr,
	output logic [31:0]      mem_wdata,
	output logic [11:0]      csr_addr,
	output logic             csr_we,
	output logic [31:0]      csr_wdata,
	output logic [1:0]       status
);

	localparam int DIV_OUT = DIV_STAGES + 1;   // stage where divider result lands
	localparam int LAST    = DIV_OUT + 1;      // output register stage

	exe_t        dec;
	ops_t        dec_ops;
	ops_t        ops_s1;
	exe_t        pay_s [1:DIV_OUT];
	exe_t        out_s;
	exe_t        mul_fix, div_fix;
	logic        vld_s [1:LAST];
	logic        en;
	logic [31:0] mul_s2;
	logic [31:0] quo, rem, quo_fix, rem_fix;

	assign en       = !vld_s[LAST] || out_ready;
	assign in_ready = en;

	rvx_decode u_dec (
		.instruction (instruction),
		.pc          (pc),
		.rs1_value   (rs1_value),
		.rs2_value   (rs2_value),
		.csr_value   (csr_value),
		.mepc_value  (mepc_value),
		.mtvec_value (mtvec_value),
		.res         (dec),
		.ops         (dec_ops)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= LAST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_comb begin
		mul_fix = pay_s[2];
		if (pay_s[2].res_sel == RES_MUL_LO || pay_s[2].res_sel == RES_MUL_HI)
			mul_fix.rd_value = mul_s2;
		div_fix = pay_s[DIV_OUT];
		if (pay_s[DIV_OUT].res_sel == RES_DIV_Q) div_fix.rd_value = quo_fix;
		else if (pay_s[DIV_OUT].res_sel == RES_DIV_R) div_fix.rd_value = rem_fix;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[1] <= dec;
			ops_s1   <= dec_ops;
			pay_s[2] <= pay_s[1];
			pay_s[3] <= mul_fix;
			for (int k = 4; k <= DIV_OUT; k++) pay_s[k] <= pay_s[k-1];
		end
	end

	rvx_mul u_mul (
		.clk     (clk),
		.en      (en),
		.a       (ops_s1.mul_a),
		.b       (ops_s1.mul_b),
		.hi      (pay_s[1].res_sel == RES_MUL_HI),
		.prod_s2 (mul_s2)
	);

	rvx_div u_div (
		.clk       (clk),
		.en        (en),
		.dividend  (ops_s1.div_n),
		.divisor   (ops_s1.div_d),
		.quotient  (quo),
		.remainder (rem)
	);

	assign quo_fix = pay_s[DIV_OUT].q_neg ? (32'd0 - quo) : quo;
	assign rem_fix = pay_s[DIV_OUT].r_neg ? (32'd0 - rem) : rem;

	always_ff @(posedge clk) begin
		if (en) out_s <= div_fix;
	end

	assign out_valid = vld_s[LAST];
	assign rd_index  = out_s.rd_index;
	assign rd_write  = out_s.rd_write;
	assign rd_value  = out_s.rd_value;
	assign next_pc   = out_s.next_pc;
	assign mem_kind  = out_s.mem_kind;
	assign mem_size  = out_s.mem_size;
	assign mem_addr  = out_s.mem_addr;
	assign mem_wdata = out_s.mem_wdata;
	assign csr_addr  = out_s.csr_addr;
	assign csr_we    = out_s.csr_we;
	assign csr_wdata = out_s.csr_wdata;
	assign status    = out_s.status;

endmodule
`default_nettype wire
